FILE: sv/tpt_pkg.sv
package tpt_pkg;

  // Table geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Capacity register
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [2:0] {
    MODE_INSERT       = 3'd0,
    MODE_COUNT_DATE   = 3'd1,
    MODE_EARLIEST     = 3'd2,
    MODE_REMOVE_MIN   = 3'd3,
    MODE_REMOVE_OWNER = 3'd4,
    MODE_CLEAR        = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NO_OWNER = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] owner_id;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  match_count;
    logic [15:0] found_owner;
    logic [4:0]  found_day;
    logic [3:0]  found_month;
    logic [11:0] found_year;
    logic [4:0]  found_hour;
    logic [5:0]  found_minute;
  } result_t;

  // One stored entry, 48 bits
  typedef struct packed {
    logic [15:0] owner_id;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic entry_t to_entry(request_t r);
    entry_t e;
    e.owner_id = r.owner_id;
    e.year     = r.year;
    e.month    = r.month;
    e.day      = r.day;
    e.hour     = r.hour;
    e.minute   = r.minute;
    return e;
  endfunction

  // Ordering key: year, month, day, hour, minute from most to least significant
  function automatic logic [31:0] entry_key(entry_t e);
    return {e.year, e.month, e.day, e.hour, e.minute};
  endfunction

endpackage

FILE: sv/timestamp_priority_table.sv
// Timestamp table of up to 16 entries held in one RAM with one read port and
// one write port. Insert, clear, an unused mode, and earliest or remove on an
// empty table return their result in the cycle after start is taken.
// Count-on-date, earliest and both removals read every held entry once, one
// RAM read per cycle. A removal that finds its entry then copies each later
// entry down by one slot, one per cycle. busy is high while a command runs
// and start is ignored then. The result is shown for exactly one cycle under
// done and must be captured there; busy is already low in that cycle, so the
// next command may be issued alongside it.
module timestamp_priority_table (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  tpt_pkg::request_t      request,
  output logic                   busy,
  input  logic                   cfg_we,
  input  logic [tpt_pkg::CFG_W-1:0] cfg_wdata,
  output logic                   done,
  output tpt_pkg::result_t       result
);

  import tpt_pkg::*;

  logic [CFG_W-1:0] capacity_limit;
  logic [CNT_W-1:0] limit;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CFG_RESET;
    end else if (cfg_we) begin
      capacity_limit <= cfg_wdata;
    end
  end

  // Clamp the limit to the table size
  always_comb begin
    if (32'(capacity_limit) < 32'(DEPTH)) begin
      limit = CNT_W'(capacity_limit);
    end else begin
      limit = CNT_W'(DEPTH);
    end
  end

  tpt_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .limit   (limit),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

endmodule

FILE: sv/tpt_ram.sv
module tpt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/tpt_seq.sv
module tpt_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  tpt_pkg::request_t      request,
  input  logic [tpt_pkg::CNT_W-1:0] limit,
  output logic                   busy,
  output logic                   done,
  output tpt_pkg::result_t       result
);

  import tpt_pkg::*;

  state_e            state;
  state_e            state_next;
  logic [CNT_W-1:0]  count;
  logic [2:0]        mode_q;
  request_t          req_q;
  logic [CNT_W-1:0]  issue_idx;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_pos;
  entry_t            rd_entry;
  entry_t            best_entry;
  logic [IDX_W-1:0]  best_pos;
  logic              hit;
  logic [CNT_W-1:0]  match_cnt;

  logic              accept;
  logic              ins_ok;
  logic              need_scan;
  logic              issue;
  logic              scan_end;
  logic              need_shift;
  logic              date_hit;
  logic              better;
  logic              owner_hit;

  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  entry_t            mem_wr_data;
  logic [ENTRY_W-1:0] mem_rd_data;

  logic              fin;
  result_t           fin_res;

  tpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign rd_entry = entry_t'(mem_rd_data);

  // Decode the command and the scan progress
  assign accept     = start && (state == ST_IDLE);
  assign ins_ok     = (request.mode == MODE_INSERT) && (count < limit);
  assign need_scan  = (request.mode == MODE_COUNT_DATE) ||
                      (((request.mode == MODE_EARLIEST) ||
                        (request.mode == MODE_REMOVE_MIN) ||
                        (request.mode == MODE_REMOVE_OWNER)) && (count != '0));
  assign issue      = issue_idx < count;
  assign scan_end   = !issue && !rd_valid;
  assign need_shift = ((mode_q == MODE_REMOVE_MIN) || (mode_q == MODE_REMOVE_OWNER)) && hit;
  assign date_hit   = (rd_entry.day == req_q.day) && (rd_entry.month == req_q.month) &&
                      (rd_entry.year == req_q.year);
  assign better     = !hit || (entry_key(rd_entry) < entry_key(best_entry));
  assign owner_hit  = !hit && (rd_entry.owner_id == req_q.owner_id);
  assign busy       = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && need_scan) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = need_shift ? ST_SHIFT : ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (scan_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls: insert write, scan reads, shift-down copy
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = issue_idx[IDX_W-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = count[IDX_W-1:0];
    mem_wr_data = to_entry(request);
    unique case (state)
      ST_IDLE: begin
        mem_wr_en = accept && ins_ok;
      end
      ST_SCAN: begin
        mem_rd_en = issue;
      end
      ST_SHIFT: begin
        mem_rd_en   = issue;
        mem_wr_en   = rd_valid;
        mem_wr_addr = IDX_W'(rd_pos - IDX_W'(1));
        mem_wr_data = rd_entry;
      end
      default: ;
    endcase
  end

  // Form the result of a finishing command
  always_comb begin
    fin     = 1'b0;
    fin_res = '0;
    fin_res.status      = STAT_OK;
    fin_res.match_count = 5'(count);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (request.mode)
            MODE_INSERT: begin
              fin = 1'b1;
              if (ins_ok) begin
                fin_res.match_count = 5'(count + CNT_W'(1));
              end else begin
                fin_res.status = STAT_FULL;
              end
            end
            MODE_COUNT_DATE: fin = 1'b0;
            MODE_EARLIEST, MODE_REMOVE_MIN, MODE_REMOVE_OWNER: begin
              fin = (count == '0);
              fin_res.status = STAT_EMPTY;
            end
            MODE_CLEAR: begin
              fin = 1'b1;
              fin_res.match_count = '0;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end && !need_shift) begin
          fin = 1'b1;
          if (mode_q == MODE_COUNT_DATE) begin
            fin_res.match_count = 5'(match_cnt);
          end else if (mode_q == MODE_REMOVE_OWNER) begin
            fin_res.status = STAT_NO_OWNER;
          end else begin
            fin_res.found_owner  = best_entry.owner_id;
            fin_res.found_day    = best_entry.day;
            fin_res.found_month  = best_entry.month;
            fin_res.found_year   = best_entry.year;
            fin_res.found_hour   = best_entry.hour;
            fin_res.found_minute = best_entry.minute;
          end
        end
      end
      ST_SHIFT: begin
        if (scan_end) begin
          fin = 1'b1;
          fin_res.match_count  = 5'(count - CNT_W'(1));
          fin_res.found_owner  = best_entry.owner_id;
          fin_res.found_day    = best_entry.day;
          fin_res.found_month  = best_entry.month;
          fin_res.found_year   = best_entry.year;
          fin_res.found_hour   = best_entry.hour;
          fin_res.found_minute = best_entry.minute;
        end
      end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
      hit      <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= mem_rd_en;
      rd_pos   <= mem_rd_addr;
      done     <= fin;
      if (fin) begin
        result <= fin_res;
      end

      // Latch the command and start a fresh scan
      if (accept) begin
        req_q     <= request;
        mode_q    <= request.mode;
        issue_idx <= '0;
        hit       <= 1'b0;
        match_cnt <= '0;
        if (ins_ok) begin
          count <= count + CNT_W'(1);
        end
        if (request.mode == MODE_CLEAR) begin
          count <= '0;
        end
      end

      // Advance the read pointer
      if (mem_rd_en) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end

      // Fold returning entries into the scan result
      if ((state == ST_SCAN) && rd_valid) begin
        if (mode_q == MODE_COUNT_DATE) begin
          if (date_hit) begin
            match_cnt <= match_cnt + CNT_W'(1);
          end
        end else if (mode_q == MODE_REMOVE_OWNER) begin
          if (owner_hit) begin
            best_entry <= rd_entry;
            best_pos   <= rd_pos;
            hit        <= 1'b1;
          end
        end else if (better) begin
          best_entry <= rd_entry;
          best_pos   <= rd_pos;
          hit        <= 1'b1;
        end
      end

      // Start the shift-down just past the removed entry
      if ((state == ST_SCAN) && scan_end && need_shift) begin
        issue_idx <= CNT_W'(best_pos) + CNT_W'(1);
      end

      // Drop the removed entry once the shift-down is done
      if ((state == ST_SHIFT) && scan_end) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/tpt_chk.sv
module tpt_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input tpt_pkg::request_t         request,
  input logic                      busy,
  input logic                      done,
  input tpt_pkg::result_t          result
);

  import tpt_pkg::*;

  // Insert answers on the next cycle
  a_insert_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.mode == MODE_INSERT)) |=> done)
    else $error("insert transfer not answered on the next cycle");

  // Clear empties the table at once
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.mode == MODE_CLEAR)) |=>
      (done && (result.status == STAT_OK) && (result.match_count == '0)))
    else $error("clear did not report an empty table");

  // A command is never still running when its result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Failed commands report no entry
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STAT_OK)) |->
      ((result.found_owner == '0) && (result.found_year == '0) &&
       (result.found_day == '0) && (result.found_minute == '0)))
    else $error("found fields set on a failed command");

  // Reported match_count stays within the table depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.match_count) <= 32'(DEPTH)))
    else $error("match_count beyond table depth");

endmodule

bind timestamp_priority_table tpt_chk u_tpt_chk (.*);
